// ===== hw/rtl/dpsg_pkg.sv =====
// ----------------------------------------------------------------------------
// dpsg_pkg
// Shared types, register offsets and lookup tables for the dual pulse sound
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dpsg_pkg;

    // Number of byte registers in the bus window.
    localparam int REG_SLOTS = 32;
    localparam int ADDR_W    = $clog2(REG_SLOTS);

    // Item commands.
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_TIMER = 2'd2,
        CMD_FRAME = 2'd3
    } cmd_t;

    // Register offsets with a function.
    localparam logic [ADDR_W-1:0] ADDR_CTRL_A   = ADDR_W'(8'h00);
    localparam logic [ADDR_W-1:0] ADDR_PLO_A    = ADDR_W'(8'h02);
    localparam logic [ADDR_W-1:0] ADDR_PHI_A    = ADDR_W'(8'h03);
    localparam logic [ADDR_W-1:0] ADDR_CTRL_B   = ADDR_W'(8'h04);
    localparam logic [ADDR_W-1:0] ADDR_PLO_B    = ADDR_W'(8'h06);
    localparam logic [ADDR_W-1:0] ADDR_PHI_B    = ADDR_W'(8'h07);
    localparam logic [ADDR_W-1:0] ADDR_PCM_CTRL = ADDR_W'(8'h10);
    localparam logic [ADDR_W-1:0] ADDR_PCM_DATA = ADDR_W'(8'h11);
    localparam logic [ADDR_W-1:0] ADDR_ENABLE   = ADDR_W'(8'h15);

    // First period above the sounding range, and the lowest one that produces sound.
    localparam logic [10:0] PERIOD_MAX = 11'h7FF;
    localparam logic [10:0] PERIOD_MIN = 11'd8;

    // Input item.
    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [7:0] read_data;
        logic [4:0] audio_level;
        logic [7:0] pcm_level;
        logic       irq_flag;
    } out_item_t;

    // Per-item controls from the bus decoder to one pulse channel.
    typedef struct packed {
        logic       item;
        logic       wr_ctrl;
        logic       wr_plo;
        logic       wr_phi;
        logic       wr_en;
        logic       tick;
        logic       frame_clk;
        logic       en_cur;
        logic       en_new;
        logic [1:0] duty;
        logic [7:0] wdata;
    } chan_ctl_t;

    // Length counter load values.
    function automatic logic [7:0] len_lookup(input logic [4:0] idx);
        logic [7:0] val;
        case (idx)
            5'd0:  val = 8'd10;
            5'd1:  val = 8'd254;
            5'd2:  val = 8'd20;
            5'd3:  val = 8'd2;
            5'd4:  val = 8'd40;
            5'd5:  val = 8'd4;
            5'd6:  val = 8'd80;
            5'd7:  val = 8'd6;
            5'd8:  val = 8'd160;
            5'd9:  val = 8'd8;
            5'd10: val = 8'd60;
            5'd11: val = 8'd10;
            5'd12: val = 8'd14;
            5'd13: val = 8'd12;
            5'd14: val = 8'd26;
            5'd15: val = 8'd14;
            5'd16: val = 8'd12;
            5'd17: val = 8'd16;
            5'd18: val = 8'd24;
            5'd19: val = 8'd18;
            5'd20: val = 8'd48;
            5'd21: val = 8'd20;
            5'd22: val = 8'd96;
            5'd23: val = 8'd22;
            5'd24: val = 8'd192;
            5'd25: val = 8'd24;
            5'd26: val = 8'd72;
            5'd27: val = 8'd26;
            5'd28: val = 8'd16;
            5'd29: val = 8'd28;
            5'd30: val = 8'd32;
            5'd31: val = 8'd30;
            default: val = 8'd0;
        endcase
        return val;
    endfunction

    // Duty waveforms, bit n is sequencer step n.
    function automatic logic duty_lookup(input logic [1:0] duty, input logic [2:0] step);
        logic [7:0] wave;
        case (duty)
            2'd0:    wave = 8'b0000_0010;
            2'd1:    wave = 8'b0000_0110;
            2'd2:    wave = 8'b0001_1110;
            2'd3:    wave = 8'b1111_1001;
            default: wave = 8'b0000_0000;
        endcase
        return wave[step];
    endfunction

    // Frame divider reload for the step being entered.
    function automatic logic [13:0] frame_reload(input logic pal, input logic [1:0] step);
        logic [13:0] val;
        if (pal)
        begin
            val = (step == 2'd1) ? 14'd8312 : 14'd8314;
        end
        else
        begin
            val = (step == 2'd0) ? 14'd7456 : 14'd7458;
        end
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dual_pulse_sound_generator_top.sv =====
// ----------------------------------------------------------------------------
// dual_pulse_sound_generator_top
// Two pulse channels with a raw PCM byte and PCM interrupt, driven by bus
// accesses and timer and frame ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item on in_valid/in_stall is a register write, a register
//   read, a timer tick or a frame tick. Every accepted item produces exactly
//   one result item on out_valid/out_stall with the read byte, the summed
//   channel levels, the PCM byte and the interrupt flag.
//   The item is processed in the cycle it is accepted and its result is
//   registered; one item can be accepted per cycle while in_stall is low.
//   The output register has a skid entry behind it: when the receiver
//   stalls, one more item is still taken, then in_stall rises until the
//   receiver drains the output. No result is lost or repeated.
//   The pal_mode register is written over cfg_valid/cfg_ready, which is
//   always ready; write it only while no item is in flight.
//   Reset clears all channel state, the register bytes, the PCM control
//   and the output buffer; the block takes items right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_pulse_sound_generator_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire dpsg_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output dpsg_pkg::out_item_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data
);

    logic                in_accept;
    logic                is_write;
    logic                is_read;
    logic                pal_mode_reg;
    logic [7:0]          reg_store_reg [dpsg_pkg::REG_SLOTS];
    logic [7:0]          pcm_byte_reg, pcm_byte_next;
    logic                read_mode_reg, read_mode_next;
    logic                irq_en_reg, irq_en_next;
    logic                irq_reg, irq_next;
    logic [1:0]          en_cur;
    logic [1:0]          en_new;
    logic [1:0]          duty_a;
    logic [1:0]          duty_b;
    logic                frame_fire;
    dpsg_pkg::chan_ctl_t ctl_a;
    dpsg_pkg::chan_ctl_t ctl_b;
    logic [3:0]          held_a;
    logic [3:0]          held_b;
    logic                len_nz_a;
    logic                len_nz_b;
    logic [7:0]          read_data;
    dpsg_pkg::out_item_t result;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && !in_stall;
    assign is_write  = in_accept && (in_data.cmd == dpsg_pkg::CMD_WRITE);
    assign is_read   = in_accept && (in_data.cmd == dpsg_pkg::CMD_READ);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pal_mode_reg <= cfg_data;
        end
    end

    // Register bytes as written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dpsg_pkg::REG_SLOTS; i++)
            begin
                reg_store_reg[i] <= '0;
            end
        end
        else if (is_write)
        begin
            reg_store_reg[in_data.addr] <= in_data.wdata;
        end
    end

    // Enables as they stand before and after this item's write, duty after it.
    always_comb
    begin
        en_cur = reg_store_reg[dpsg_pkg::ADDR_ENABLE][1:0];
        en_new = en_cur;
        duty_a = reg_store_reg[dpsg_pkg::ADDR_CTRL_A][7:6];
        duty_b = reg_store_reg[dpsg_pkg::ADDR_CTRL_B][7:6];
        if (is_write && (in_data.addr == dpsg_pkg::ADDR_ENABLE))
        begin
            en_new = in_data.wdata[1:0];
        end
        if (is_write && (in_data.addr == dpsg_pkg::ADDR_CTRL_A))
        begin
            duty_a = in_data.wdata[7:6];
        end
        if (is_write && (in_data.addr == dpsg_pkg::ADDR_CTRL_B))
        begin
            duty_b = in_data.wdata[7:6];
        end
    end

    // Frame divider.
    dpsg_frame u_frame (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (in_accept && (in_data.cmd == dpsg_pkg::CMD_FRAME)),
        .pal_mode (pal_mode_reg),
        .fire     (frame_fire)
    );

    // Channel controls.
    always_comb
    begin
        ctl_a.item      = in_accept;
        ctl_a.wr_ctrl   = is_write && (in_data.addr == dpsg_pkg::ADDR_CTRL_A);
        ctl_a.wr_plo    = is_write && (in_data.addr == dpsg_pkg::ADDR_PLO_A);
        ctl_a.wr_phi    = is_write && (in_data.addr == dpsg_pkg::ADDR_PHI_A);
        ctl_a.wr_en     = is_write && (in_data.addr == dpsg_pkg::ADDR_ENABLE);
        ctl_a.tick      = in_accept && (in_data.cmd == dpsg_pkg::CMD_TIMER);
        ctl_a.frame_clk = frame_fire;
        ctl_a.en_cur    = en_cur[0];
        ctl_a.en_new    = en_new[0];
        ctl_a.duty      = duty_a;
        ctl_a.wdata     = in_data.wdata;

        ctl_b           = ctl_a;
        ctl_b.wr_ctrl   = is_write && (in_data.addr == dpsg_pkg::ADDR_CTRL_B);
        ctl_b.wr_plo    = is_write && (in_data.addr == dpsg_pkg::ADDR_PLO_B);
        ctl_b.wr_phi    = is_write && (in_data.addr == dpsg_pkg::ADDR_PHI_B);
        ctl_b.en_cur    = en_cur[1];
        ctl_b.en_new    = en_new[1];
        ctl_b.duty      = duty_b;
    end

    dpsg_channel u_chan_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_a),
        .held_next (held_a),
        .length_nz (len_nz_a)
    );

    dpsg_channel u_chan_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_b),
        .held_next (held_b),
        .length_nz (len_nz_b)
    );

    // PCM control and register reads.
    always_comb
    begin
        pcm_byte_next  = pcm_byte_reg;
        read_mode_next = read_mode_reg;
        irq_en_next    = irq_en_reg;
        irq_next       = irq_reg;
        read_data      = 8'd0;
        if (is_write && (in_data.addr == dpsg_pkg::ADDR_PCM_CTRL))
        begin
            read_mode_next = in_data.wdata[0];
            irq_en_next    = in_data.wdata[7];
            if (!in_data.wdata[7])
            begin
                irq_next = 1'b0;
            end
        end
        if (is_write && (in_data.addr == dpsg_pkg::ADDR_PCM_DATA) && !read_mode_reg)
        begin
            pcm_byte_next = in_data.wdata;
            if ((in_data.wdata == 8'd0) && irq_en_reg)
            begin
                irq_next = 1'b1;
            end
        end
        if (is_read)
        begin
            case (in_data.addr)
                dpsg_pkg::ADDR_PCM_CTRL:
                begin
                    read_data = {irq_reg, 7'd0};
                    irq_next  = 1'b0;
                end
                dpsg_pkg::ADDR_ENABLE:
                begin
                    read_data = {6'd0, len_nz_b, len_nz_a};
                end
                default:
                begin
                    read_data = reg_store_reg[in_data.addr];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcm_byte_reg  <= '0;
            read_mode_reg <= 1'b0;
            irq_en_reg    <= 1'b0;
            irq_reg       <= 1'b0;
        end
        else
        begin
            pcm_byte_reg  <= pcm_byte_next;
            read_mode_reg <= read_mode_next;
            irq_en_reg    <= irq_en_next;
            irq_reg       <= irq_next;
        end
    end

    // Result item.
    always_comb
    begin
        result.read_data   = read_data;
        result.audio_level = 5'(held_a) + 5'(held_b);
        result.pcm_level   = pcm_byte_next;
        result.irq_flag    = irq_next;
    end

    dpsg_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data (result),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    // A stalled result stays presented until the receiver takes it.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

    // The interrupt is raised only by an accepted item.
    a_irq_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(irq_reg) |-> $past(in_accept))
        else $error("interrupt raised without an item");

    // Two 4-bit levels never sum beyond 30.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.audio_level <= 5'd30))
        else $error("audio level out of range");

    // A read of the PCM control clears the pending interrupt.
    a_irq_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (is_read && (in_data.addr == dpsg_pkg::ADDR_PCM_CTRL)) |=> !irq_reg)
        else $error("interrupt not cleared by status read");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/dpsg_channel.sv =====
// ----------------------------------------------------------------------------
// dpsg_channel
// One pulse channel: period, duty sequencer timer, length counter, envelope
// and the held output level.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsg_channel (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dpsg_pkg::chan_ctl_t ctl,
    output logic [3:0]               held_next,
    output logic                     length_nz
);

    logic [10:0] period_reg, period_next;
    logic [12:0] timer_reg, timer_next;
    logic [2:0]  step_reg, step_next;
    logic [7:0]  length_reg, length_next;
    logic [3:0]  decay_reg, decay_next;
    logic [3:0]  div_reg, div_next;
    logic [3:0]  vol_reg, vol_next;
    logic        const_reg, const_next;
    logic        loop_reg, loop_next;
    logic        start_reg, start_next;
    logic [3:0]  held_reg;
    logic [12:0] timer_dec;
    logic [12:0] timer_load;
    logic [3:0]  level;

    assign timer_dec  = (timer_reg != 13'd0) ? timer_reg - 13'd1 : 13'd0;
    assign timer_load = {12'(period_reg) + 12'd1, 1'b0};

    // Next state of the channel for the current item.
    always_comb
    begin
        period_next = period_reg;
        timer_next  = timer_reg;
        step_next   = step_reg;
        length_next = length_reg;
        decay_next  = decay_reg;
        div_next    = div_reg;
        vol_next    = vol_reg;
        const_next  = const_reg;
        loop_next   = loop_reg;
        start_next  = start_reg;

        if (ctl.wr_ctrl)
        begin
            vol_next   = ctl.wdata[3:0];
            const_next = ctl.wdata[4];
            loop_next  = ctl.wdata[5];
        end

        if (ctl.wr_plo)
        begin
            period_next[7:0] = ctl.wdata;
        end

        // A period high write restarts the sequencer and the envelope.
        if (ctl.wr_phi)
        begin
            period_next[10:8] = ctl.wdata[2:0];
            step_next         = 3'd0;
            start_next        = 1'b1;
            if (ctl.en_cur)
            begin
                length_next = dpsg_pkg::len_lookup(ctl.wdata[7:3]);
            end
        end

        if (ctl.wr_en && !ctl.en_new)
        begin
            length_next = 8'd0;
        end

        // Timer tick: count down, reload and step the sequencer at zero.
        if (ctl.tick)
        begin
            if (timer_dec == 13'd0)
            begin
                timer_next = timer_load;
                step_next  = step_reg + 3'd1;
            end
            else
            begin
                timer_next = timer_dec;
            end
        end

        // Frame clock: envelope and length, only while the length is running.
        if (ctl.frame_clk && (length_reg != 8'd0))
        begin
            if (start_reg)
            begin
                start_next = 1'b0;
                div_next   = vol_reg;
                decay_next = 4'd15;
            end
            else if (div_reg == 4'd0)
            begin
                div_next = vol_reg;
                if (decay_reg == 4'd0)
                begin
                    if (loop_reg)
                    begin
                        decay_next = 4'd15;
                    end
                end
                else
                begin
                    decay_next = decay_reg - 4'd1;
                end
            end
            else
            begin
                div_next = div_reg - 4'd1;
            end
            if (!loop_reg)
            begin
                length_next = length_reg - 8'd1;
            end
        end
    end

    // Held level is refreshed after every item while the channel sounds.
    always_comb
    begin
        level     = const_next ? vol_next : decay_next;
        held_next = held_reg;
        if (ctl.item && (length_next != 8'd0) && ctl.en_new &&
            (period_next >= dpsg_pkg::PERIOD_MIN) && (period_next != dpsg_pkg::PERIOD_MAX))
        begin
            held_next = dpsg_pkg::duty_lookup(ctl.duty, step_next) ? level : 4'd0;
        end
    end

    assign length_nz = (length_reg != 8'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            timer_reg  <= '0;
            step_reg   <= '0;
            length_reg <= '0;
            decay_reg  <= '0;
            div_reg    <= '0;
            vol_reg    <= '0;
            const_reg  <= 1'b0;
            loop_reg   <= 1'b0;
            start_reg  <= 1'b0;
            held_reg   <= '0;
        end
        else
        begin
            period_reg <= period_next;
            timer_reg  <= timer_next;
            step_reg   <= step_next;
            length_reg <= length_next;
            decay_reg  <= decay_next;
            div_reg    <= div_next;
            vol_reg    <= vol_next;
            const_reg  <= const_next;
            loop_reg   <= loop_next;
            start_reg  <= start_next;
            held_reg   <= held_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dpsg_frame.sv =====
// ----------------------------------------------------------------------------
// dpsg_frame
// Four-step frame divider that issues the envelope and length clock.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsg_frame (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic tick,
    input  wire logic pal_mode,
    output logic      fire
);

    logic [1:0]  frame_step_reg, frame_step_next;
    logic [13:0] frame_count_reg, frame_count_next;
    logic [13:0] count_dec;

    assign count_dec = (frame_count_reg != 14'd0) ? frame_count_reg - 14'd1 : 14'd0;

    // Count down on each frame tick; at zero clock the channels and reload.
    always_comb
    begin
        fire             = 1'b0;
        frame_step_next  = frame_step_reg;
        frame_count_next = frame_count_reg;
        if (tick)
        begin
            if (count_dec == 14'd0)
            begin
                fire             = 1'b1;
                frame_step_next  = frame_step_reg + 2'd1;
                frame_count_next = dpsg_pkg::frame_reload(pal_mode, frame_step_next);
            end
            else
            begin
                frame_count_next = count_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_step_reg  <= '0;
            frame_count_reg <= '0;
        end
        else
        begin
            frame_step_reg  <= frame_step_next;
            frame_count_reg <= frame_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dpsg_outbuf.sv =====
// ----------------------------------------------------------------------------
// dpsg_outbuf
// Result register with a skid entry, so that a new item can be taken while
// a finished result waits for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsg_outbuf (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire dpsg_pkg::out_item_t push_data,
    output logic                     full,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output dpsg_pkg::out_item_t      out_data
);

    logic                valid_reg, valid_next;
    logic                skid_valid_reg, skid_valid_next;
    dpsg_pkg::out_item_t data_reg, data_next;
    dpsg_pkg::out_item_t skid_reg, skid_next;
    logic                take;

    assign take      = valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Move items from the skid entry or the input into the output register.
    always_comb
    begin
        valid_next      = valid_reg;
        skid_valid_next = skid_valid_reg;
        data_next       = data_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                data_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!valid_reg || take)
            begin
                data_next  = push_data;
                valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire
